>>> sv/vqnc_pkg.sv
package vqnc_pkg;

   localparam int ELEMENT_BITS = 16;
   localparam int NUM_ELEMENTS = 8;
   localparam int INDEX_BITS = 8;
   localparam int DIST_BITS = 35;

   localparam int DEF_CODEBOOK_SIZE = 256;
   localparam int DEF_VECTOR_DIM = 8;

   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_QUERY = 1'b1
   } command_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FETCH,
      ST_OUT
   } state_type;

   typedef struct packed {
      command_type                     command;
      logic [INDEX_BITS-1:0]           entry_index;
      logic signed [ELEMENT_BITS-1:0]  element0;
      logic signed [ELEMENT_BITS-1:0]  element1;
      logic signed [ELEMENT_BITS-1:0]  element2;
      logic signed [ELEMENT_BITS-1:0]  element3;
      logic signed [ELEMENT_BITS-1:0]  element4;
      logic signed [ELEMENT_BITS-1:0]  element5;
      logic signed [ELEMENT_BITS-1:0]  element6;
      logic signed [ELEMENT_BITS-1:0]  element7;
   } req_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0]           code_index;
      logic [DIST_BITS-1:0]            min_distance;
      logic signed [ELEMENT_BITS-1:0]  chosen0;
      logic signed [ELEMENT_BITS-1:0]  chosen1;
      logic signed [ELEMENT_BITS-1:0]  chosen2;
      logic signed [ELEMENT_BITS-1:0]  chosen3;
      logic signed [ELEMENT_BITS-1:0]  chosen4;
      logic signed [ELEMENT_BITS-1:0]  chosen5;
      logic signed [ELEMENT_BITS-1:0]  chosen6;
      logic signed [ELEMENT_BITS-1:0]  chosen7;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic last;
   } chain_ctl_type;

endpackage

>>> sv/vqnc_ram.sv
module vqnc_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/vqnc_cell.sv
module vqnc_cell import vqnc_pkg::*; #(
   parameter int CODEBOOK_SIZE = DEF_CODEBOOK_SIZE,
   parameter int VECTOR_DIM = DEF_VECTOR_DIM,
   parameter int LANE = 0
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         q_load,
   input  logic signed [ELEMENT_BITS-1:0]               q_value,
   input  chain_ctl_type                                ctl_in,
   input  logic [$clog2(CODEBOOK_SIZE)-1:0]             idx_in,
   input  logic [VECTOR_DIM-1:0][ELEMENT_BITS-1:0]      vec_in,
   input  logic [2*ELEMENT_BITS+$clog2(VECTOR_DIM)-1:0] sum_in,
   output chain_ctl_type                                ctl_out,
   output logic [$clog2(CODEBOOK_SIZE)-1:0]             idx_out,
   output logic [VECTOR_DIM-1:0][ELEMENT_BITS-1:0]      vec_out,
   output logic [2*ELEMENT_BITS+$clog2(VECTOR_DIM)-1:0] sum_out
);

   localparam int IDX_W = $clog2(CODEBOOK_SIZE);
   localparam int SUM_W = 2*ELEMENT_BITS + $clog2(VECTOR_DIM);

   logic signed [ELEMENT_BITS-1:0]          q_ff;
   logic signed [ELEMENT_BITS:0]            diff;
   logic signed [2*ELEMENT_BITS+1:0]        prod;

   chain_ctl_type                           ctl_a_ff;
   logic [IDX_W-1:0]                        idx_a_ff;
   logic [VECTOR_DIM-1:0][ELEMENT_BITS-1:0] vec_a_ff;
   logic [SUM_W-1:0]                        sum_a_ff;
   logic [2*ELEMENT_BITS-1:0]               sq_ff;

   chain_ctl_type                           ctl_b_ff;
   logic [IDX_W-1:0]                        idx_b_ff;
   logic [VECTOR_DIM-1:0][ELEMENT_BITS-1:0] vec_b_ff;
   logic [SUM_W-1:0]                        sum_b_ff;

   assign diff = $signed({vec_in[LANE][ELEMENT_BITS-1], vec_in[LANE]})
               - $signed({q_ff[ELEMENT_BITS-1], q_ff});
   assign prod = diff * diff;

   always_ff @(posedge clock) begin
      if (q_load) begin
         q_ff <= q_value;
      end
   end

   // square stage
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
      end else begin
         ctl_a_ff <= ctl_in;
      end
      idx_a_ff <= idx_in;
      vec_a_ff <= vec_in;
      sum_a_ff <= sum_in;
      sq_ff    <= prod[2*ELEMENT_BITS-1:0];
   end

   // accumulate stage
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_b_ff <= '0;
      end else begin
         ctl_b_ff <= ctl_a_ff;
      end
      idx_b_ff <= idx_a_ff;
      vec_b_ff <= vec_a_ff;
      sum_b_ff <= sum_a_ff + SUM_W'(sq_ff);
   end

   assign ctl_out = ctl_b_ff;
   assign idx_out = idx_b_ff;
   assign vec_out = vec_b_ff;
   assign sum_out = sum_b_ff;

endmodule

>>> sv/vqnc_min_sel.sv
module vqnc_min_sel import vqnc_pkg::*; #(
   parameter int CODEBOOK_SIZE = DEF_CODEBOOK_SIZE,
   parameter int VECTOR_DIM = DEF_VECTOR_DIM
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  chain_ctl_type                                ctl_in,
   input  logic [$clog2(CODEBOOK_SIZE)-1:0]             idx_in,
   input  logic [2*ELEMENT_BITS+$clog2(VECTOR_DIM)-1:0] sum_in,
   output logic                                         done,
   output logic [$clog2(CODEBOOK_SIZE)-1:0]             best_idx,
   output logic [2*ELEMENT_BITS+$clog2(VECTOR_DIM)-1:0] best_sum
);

   localparam int IDX_W = $clog2(CODEBOOK_SIZE);
   localparam int SUM_W = 2*ELEMENT_BITS + $clog2(VECTOR_DIM);

   logic             done_ff;
   logic [IDX_W-1:0] best_idx_ff;
   logic [SUM_W-1:0] best_sum_ff;
   logic             take;

   // first entry always taken, later ones only when strictly closer
   assign take = ctl_in.valid && ((idx_in == '0) || (sum_in < best_sum_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= ctl_in.valid && ctl_in.last;
      end
      if (take) begin
         best_idx_ff <= idx_in;
         best_sum_ff <= sum_in;
      end
   end

   assign done     = done_ff;
   assign best_idx = best_idx_ff;
   assign best_sum = best_sum_ff;

endmodule

>>> sv/vq_nearest_codeword_core.sv
// nearest codeword search over a stored codebook
// input channel (req_*): one transaction per command. a load writes
// entry_index with element0..VECTOR_DIM-1 and gives no result; loads
// beyond the codebook are dropped. a query searches the whole codebook.
// result channel (rsp_*): one transaction per query with the lowest index
// of least squared distance, that distance and the chosen codeword;
// chosen elements beyond VECTOR_DIM read as zero.
// a query reads the codebook ram one entry per cycle into a chain of
// VECTOR_DIM cells, two stages each, then a min select stage and a
// re-read of the winning entry.
// req_stall is high from query acceptance until its result is loaded into
// the output register; loads are taken while a result waits there.
// a stalled result holds in the output register; the next query's result
// waits until it is taken.
// reset clears control state only; the codebook is undefined until loaded
// and every entry must be loaded before a query.
module vq_nearest_codeword_core import vqnc_pkg::*; #(
   parameter int CODEBOOK_SIZE = DEF_CODEBOOK_SIZE,
   parameter int VECTOR_DIM = DEF_VECTOR_DIM
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   localparam int IDX_W = $clog2(CODEBOOK_SIZE);
   localparam int SUM_W = 2*ELEMENT_BITS + $clog2(VECTOR_DIM);
   localparam int ROW_W = VECTOR_DIM * ELEMENT_BITS;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CODEBOOK_SIZE - 1);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             req_accept;
   logic             q_load;
   logic             wr_en;
   logic             rsp_load;

   logic signed [ELEMENT_BITS-1:0] req_elem [NUM_ELEMENTS];
   logic signed [ELEMENT_BITS-1:0] chosen_elem [NUM_ELEMENTS];

   logic [VECTOR_DIM-1:0][ELEMENT_BITS-1:0] wr_row;
   logic [VECTOR_DIM-1:0][ELEMENT_BITS-1:0] rd_row;
   logic [IDX_W-1:0]                        rd_addr;

   chain_ctl_type    issue_ctl_ff;
   logic [IDX_W-1:0] issue_idx_ff;

   chain_ctl_type                           chain_ctl [VECTOR_DIM+1];
   logic [IDX_W-1:0]                        chain_idx [VECTOR_DIM+1];
   logic [VECTOR_DIM-1:0][ELEMENT_BITS-1:0] chain_vec [VECTOR_DIM+1];
   logic [SUM_W-1:0]                        chain_sum [VECTOR_DIM+1];

   logic             done;
   logic [IDX_W-1:0] best_idx;
   logic [SUM_W-1:0] best_sum;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   assign req_elem[0] = req_payload.element0;
   assign req_elem[1] = req_payload.element1;
   assign req_elem[2] = req_payload.element2;
   assign req_elem[3] = req_payload.element3;
   assign req_elem[4] = req_payload.element4;
   assign req_elem[5] = req_payload.element5;
   assign req_elem[6] = req_payload.element6;
   assign req_elem[7] = req_payload.element7;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign q_load     = req_accept && (req_payload.command == CMD_QUERY);
   assign wr_en      = req_accept && (req_payload.command == CMD_LOAD)
                    && (32'(req_payload.entry_index) < 32'(CODEBOOK_SIZE));

   for (genvar k = 0; k < VECTOR_DIM; k++) begin : g_row
      assign wr_row[k] = req_elem[k];
   end

   assign rd_addr = (state_ff == ST_SCAN) ? cnt_ff : best_idx;

   vqnc_ram #(
      .WIDTH (ROW_W),
      .DEPTH (CODEBOOK_SIZE)
   ) u_codebook (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (IDX_W'(req_payload.entry_index)),
      .wr_data (wr_row),
      .rd_addr (rd_addr),
      .rd_data (rd_row)
   );

   // tag travels with the registered read data
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ctl_ff <= '0;
      end else begin
         issue_ctl_ff.valid <= (state_ff == ST_SCAN);
         issue_ctl_ff.last  <= (cnt_ff == LAST_IDX);
      end
      issue_idx_ff <= cnt_ff;
   end

   assign chain_ctl[0] = issue_ctl_ff;
   assign chain_idx[0] = issue_idx_ff;
   assign chain_vec[0] = rd_row;
   assign chain_sum[0] = '0;

   for (genvar k = 0; k < VECTOR_DIM; k++) begin : g_cell
      vqnc_cell #(
         .CODEBOOK_SIZE (CODEBOOK_SIZE),
         .VECTOR_DIM    (VECTOR_DIM),
         .LANE          (k)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .q_load  (q_load),
         .q_value (req_elem[k]),
         .ctl_in  (chain_ctl[k]),
         .idx_in  (chain_idx[k]),
         .vec_in  (chain_vec[k]),
         .sum_in  (chain_sum[k]),
         .ctl_out (chain_ctl[k+1]),
         .idx_out (chain_idx[k+1]),
         .vec_out (chain_vec[k+1]),
         .sum_out (chain_sum[k+1])
      );
   end

   vqnc_min_sel #(
      .CODEBOOK_SIZE (CODEBOOK_SIZE),
      .VECTOR_DIM    (VECTOR_DIM)
   ) u_min_sel (
      .clock    (clock),
      .reset    (reset),
      .ctl_in   (chain_ctl[VECTOR_DIM]),
      .idx_in   (chain_idx[VECTOR_DIM]),
      .sum_in   (chain_sum[VECTOR_DIM]),
      .done     (done),
      .best_idx (best_idx),
      .best_sum (best_sum)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff <= cnt_in;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (q_load) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (done) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   for (genvar k = 0; k < NUM_ELEMENTS; k++) begin : g_chosen
      if (k < VECTOR_DIM) begin : g_used
         assign chosen_elem[k] = rd_row[k];
      end else begin : g_unused
         assign chosen_elem[k] = '0;
      end
   end

   always_comb begin
      rsp_data_in              = '0;
      rsp_data_in.code_index   = INDEX_BITS'(best_idx);
      rsp_data_in.min_distance = DIST_BITS'(best_sum);
      rsp_data_in.chosen0      = chosen_elem[0];
      rsp_data_in.chosen1      = chosen_elem[1];
      rsp_data_in.chosen2      = chosen_elem[2];
      rsp_data_in.chosen3      = chosen_elem[3];
      rsp_data_in.chosen4      = chosen_elem[4];
      rsp_data_in.chosen5      = chosen_elem[5];
      rsp_data_in.chosen6      = chosen_elem[6];
      rsp_data_in.chosen7      = chosen_elem[7];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

`ifndef SYNTHESIS
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside output state");

   a_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      done |-> (state_ff == ST_DRAIN))
      else $error("search finished outside drain state");

   a_chain_busy: assert property (@(posedge clock) disable iff (reset)
      chain_ctl[VECTOR_DIM].valid |-> (state_ff == ST_SCAN || state_ff == ST_DRAIN))
      else $error("chain output while no search is running");

   a_no_load_mid_search: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !wr_en)
      else $error("codebook written during search");
`endif

endmodule

>>> tb/tb_vq_nearest_codeword_core.sv
module tb_vq_nearest_codeword_core;
   import vqnc_pkg::*;

   localparam int ENTRIES = 256;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = 400;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   logic [127:0] codebook_copy [ENTRIES];
   rsp_type      pending_matches [$];

   int idle_pct = 0;
   int stall_left = 0;
   int cycles = 0;
   int loads_seen = 0;
   int queries_seen = 0;
   int results_seen = 0;
   int errors = 0;

   vq_nearest_codeword_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic rsp_type nearest_match(logic [127:0] query_vec);
      rsp_type match;
      longint  best_dist;
      longint  sq_sum;
      longint  diff;
      int      best;
      best = 0;
      best_dist = 0;
      for (int i = 0; i < ENTRIES; i++) begin
         sq_sum = 0;
         for (int e = 0; e < NUM_ELEMENTS; e++) begin
            diff = longint'($signed(query_vec[127-16*e -: 16]))
                 - longint'($signed(codebook_copy[i][127-16*e -: 16]));
            sq_sum += diff * diff;
         end
         if (i == 0 || sq_sum < best_dist) begin
            best_dist = sq_sum;
            best = i;
         end
      end
      match.code_index = best[7:0];
      match.min_distance = best_dist[DIST_BITS-1:0];
      {match.chosen0, match.chosen1, match.chosen2, match.chosen3,
       match.chosen4, match.chosen5, match.chosen6, match.chosen7} = codebook_copy[best];
      return match;
   endfunction

   function automatic req_type make_req(command_type cmd, logic [7:0] idx,
                                        logic [127:0] vec);
      req_type r;
      r.command = cmd;
      r.entry_index = idx;
      {r.element0, r.element1, r.element2, r.element3,
       r.element4, r.element5, r.element6, r.element7} = vec;
      return r;
   endfunction

   // 0: full range, 1: small cluster around zero, 2: corner values
   function automatic logic [127:0] rand_vec(int style);
      logic [127:0] vec;
      logic [15:0]  corners [5] = '{16'h8000, 16'hffff, 16'h0000, 16'h0001, 16'h7fff};
      for (int e = 0; e < NUM_ELEMENTS; e++) begin
         case (style)
            0: vec[127-16*e -: 16] = 16'($urandom);
            1: vec[127-16*e -: 16] = 16'($urandom_range(0, 1023)) - 16'd512;
            default: vec[127-16*e -: 16] = corners[$urandom_range(0, 4)];
         endcase
      end
      return vec;
   endfunction

   // reference state and result checks at each accepted transaction
   always @(posedge clock) begin
      rsp_type want;
      logic    bad;
      cycles <= cycles + 1;
      if (!reset && req_valid && !req_stall) begin
         if (req_payload.command == CMD_LOAD) begin
            codebook_copy[req_payload.entry_index] =
               {req_payload.element0, req_payload.element1, req_payload.element2,
                req_payload.element3, req_payload.element4, req_payload.element5,
                req_payload.element6, req_payload.element7};
            loads_seen++;
         end else begin
            pending_matches.insert(pending_matches.size(), nearest_match(
               {req_payload.element0, req_payload.element1, req_payload.element2,
                req_payload.element3, req_payload.element4, req_payload.element5,
                req_payload.element6, req_payload.element7}));
            queries_seen++;
         end
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_matches.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result: index %0d distance %0d",
                        rsp_payload.code_index, rsp_payload.min_distance);
         end else begin
            want = pending_matches.pop_front();
            bad = (rsp_payload.code_index !== want.code_index)
               || (rsp_payload.min_distance !== want.min_distance)
               || (rsp_payload.chosen0 !== want.chosen0)
               || (rsp_payload.chosen1 !== want.chosen1)
               || (rsp_payload.chosen2 !== want.chosen2)
               || (rsp_payload.chosen3 !== want.chosen3)
               || (rsp_payload.chosen4 !== want.chosen4)
               || (rsp_payload.chosen5 !== want.chosen5)
               || (rsp_payload.chosen6 !== want.chosen6)
               || (rsp_payload.chosen7 !== want.chosen7);
            if (bad) begin
               errors++;
               if (errors <= 10) begin
                  $display("mismatch exp: index %0d distance %0d chosen %h",
                           want.code_index, want.min_distance,
                           {want.chosen0, want.chosen1, want.chosen2, want.chosen3,
                            want.chosen4, want.chosen5, want.chosen6, want.chosen7});
                  $display("         got: index %0d distance %0d chosen %h",
                           rsp_payload.code_index, rsp_payload.min_distance,
                           {rsp_payload.chosen0, rsp_payload.chosen1,
                            rsp_payload.chosen2, rsp_payload.chosen3,
                            rsp_payload.chosen4, rsp_payload.chosen5,
                            rsp_payload.chosen6, rsp_payload.chosen7});
               end
            end
         end
      end
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb_vq_nearest_codeword_core failed");
         $finish;
      end
   end

   // result side back pressure in bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 4);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_item(input req_type item);
      if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_matches.size() != 0);
   endtask

   task automatic fill_codebook(input bit randomized, input logic [127:0] pattern);
      for (int i = 0; i < ENTRIES; i++)
         send_item(make_req(CMD_LOAD, 8'(i), randomized ? rand_vec(i % 3) : pattern));
   endtask

   task automatic test_extreme_distances();
      idle_pct = 20;
      fill_codebook(1'b0, {8{16'h7fff}});
      // every entry ties at the largest distance
      send_item(make_req(CMD_QUERY, 8'h00, {8{16'h8000}}));
      send_item(make_req(CMD_QUERY, 8'hff, {8{16'h7fff}}));
      send_item(make_req(CMD_LOAD, 8'hff, {8{16'h8000}}));
      send_item(make_req(CMD_QUERY, 8'h00, {8{16'h8000}}));
      send_item(make_req(CMD_QUERY, 8'h5a, {4{16'h7fff, 16'h8000}}));
      send_item(make_req(CMD_QUERY, 8'ha5, {4{16'h8000, 16'h7fff}}));
   endtask

   task automatic test_tie_break();
      idle_pct = 10;
      send_item(make_req(CMD_LOAD, 8'd10, {8{16'h0064}}));
      send_item(make_req(CMD_LOAD, 8'd20, {8{16'hff9c}}));
      send_item(make_req(CMD_QUERY, 8'h00, '0));
      send_item(make_req(CMD_LOAD, 8'd5, {8{16'hff9c}}));
      send_item(make_req(CMD_QUERY, 8'hff, '0));
      send_item(make_req(CMD_QUERY, 8'h14, {8{16'hff9c}}));
      send_item(make_req(CMD_LOAD, 8'd128, {4{16'h0064, 16'hff9c}}));
      send_item(make_req(CMD_QUERY, 8'h80, {4{16'h0064, 16'hff9c}}));
      send_item(make_req(CMD_QUERY, 8'h01, {8{16'h0001}}));
   endtask

   task automatic test_random_codebook();
      idle_pct = 30;
      fill_codebook(1'b1, '0);
      send_item(make_req(CMD_QUERY, 8'($urandom), rand_vec(0)));
   endtask

   // sender holds off until each result is back
   task automatic test_drain_between_queries();
      idle_pct = 15;
      for (int n = 0; n < 4; n++) begin
         send_item(make_req(CMD_QUERY, 8'($urandom), rand_vec(n % 3)));
         wait_drain();
         send_item(make_req(CMD_LOAD, 8'($urandom), rand_vec(1)));
      end
   endtask

   task automatic test_random_traffic(input int count, input int idle);
      logic [127:0] vec;
      int           pick;
      int           k;
      idle_pct = idle;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         k = $urandom_range(0, ENTRIES - 1);
         if (pick < 35) begin
            send_item(make_req(CMD_LOAD, 8'($urandom), rand_vec($urandom_range(0, 2))));
         end else if (pick < 45) begin
            // duplicate entry so ties come up
            send_item(make_req(CMD_LOAD, 8'($urandom), codebook_copy[k]));
         end else if (pick < 60) begin
            send_item(make_req(CMD_QUERY, 8'($urandom), codebook_copy[k]));
         end else if (pick < 85) begin
            vec = codebook_copy[k];
            for (int e = 0; e < NUM_ELEMENTS; e++)
               vec[127-16*e -: 16] = vec[127-16*e -: 16] + 16'($urandom_range(0, 63)) - 16'd32;
            send_item(make_req(CMD_QUERY, 8'($urandom), vec));
         end else begin
            send_item(make_req(CMD_QUERY, 8'($urandom), rand_vec($urandom_range(0, 2))));
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_extreme_distances();
      test_tie_break();
      test_random_codebook();
      test_drain_between_queries();
      test_random_traffic(100, 25);
      test_random_traffic(64, 50);
      test_random_traffic(100, 0);
      wait_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("ran %0d codebook loads and %0d nearest codeword queries", loads_seen,
               queries_seen);
      $display("checked %0d results, extreme distances and tie breaks included", results_seen);
      if (errors == 0) begin
         $display("tb_vq_nearest_codeword_core passed");
      end else begin
         $display("%0d errors", errors);
         $display("tb_vq_nearest_codeword_core failed");
      end
      $finish;
   end

endmodule
